### rtl/fdac_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fall detect alarm controller.
// No dependencies.
package fdac_pkg;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_FALL   = 2'd1,
        MODE_ALARM  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        DISP_BLANK = 2'd0,
        DISP_FALL  = 2'd1,
        DISP_HELP  = 2'd2
    } t_disp;

    typedef enum logic [2:0] {
        CFG_LOW_MAG_SQ     = 3'd0,
        CFG_HIGH_MAG_SQ    = 3'd1,
        CFG_TILT_FACTOR_Q8 = 3'd2,
        CFG_CONFIRM_TICKS  = 3'd3,
        CFG_BLINK_PERIOD   = 3'd4,
        CFG_BLINK_ON_TICKS = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_SQX,
        SEQ_SQY,
        SEQ_SQZ,
        SEQ_TLX,
        SEQ_TLY,
        SEQ_EVAL,
        SEQ_MOD,
        SEQ_DONE
    } t_seq_state;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned MAG_W      = 32;
    localparam int unsigned TILT_W     = 10;
    localparam int unsigned TICK_W     = 16;
    localparam int unsigned FIELD_W    = 16;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [MAG_W-1:0]  LOW_MAG_SQ_RST     = 32'd500000000;
    localparam logic [MAG_W-1:0]  HIGH_MAG_SQ_RST    = 32'd1200000000;
    localparam logic [TILT_W-1:0] TILT_FACTOR_RST    = 10'd275;
    localparam logic [TICK_W-1:0] CONFIRM_TICKS_RST  = 16'd3000;
    localparam logic [TICK_W-1:0] BLINK_PERIOD_RST   = 16'd500;
    localparam logic [TICK_W-1:0] BLINK_ON_TICKS_RST = 16'd250;

endpackage

### rtl/fall_detect_alarm_controller_top.sv
`timescale 1ns / 1ps
// Fall detect alarm controller, top level: sequencer, state and ports.
// Depends on fdac_pkg, fdac_mul and fdac_mod.
//
// One request is one 1 ms tick with the held accelerometer sample and the
// key flag; each request yields exactly one result.  The block handles one
// request at a time through a single shared registered multiplier: in the
// normal mode the three squares and the two tilt products go through it in
// turn.  In the alarming mode the blink phase is a 16-bit remainder worked
// out one bit per cycle.  Fall detected, key press and unused mode codes
// need no arithmetic.  s_axis_tready is high only while the sequencer is
// idle; a finished result waits in the output register, so the next request
// may be taken while it is pending.  Configuration is written through
// i_cfg_we / i_cfg_index / i_cfg_data and must only change while the block
// is idle.  SAMPLE_BITS selects how many low bits of each sample field
// count, as a two's complement value.
module fall_detect_alarm_controller_top
    import fdac_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request side
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] accel_x_sample, [31:16] accel_y_sample, [47:32] accel_z_sample,
    // [48] key_pressed, [55:49] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result side
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] alarm_led_n, [1] buzzer_n, [2] heartbeat_led, [4:3] display_mode,
    // [5] alarm_pulse, [7:6] mode_now
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // widths follow from the sample width
    localparam int unsigned SB    = SAMPLE_BITS;
    localparam int unsigned SQ_W  = 2 * SB;            // one square
    localparam int unsigned A_W   = 2 * SB + 1;        // sum of two squares
    localparam int unsigned B_W   = (SB > TILT_W) ? SB : TILT_W;
    localparam int unsigned PW    = A_W + B_W;         // product width
    localparam int unsigned SUM_W = 2 * SB + 2;        // sum of three squares
    localparam int unsigned CMP_W = (SUM_W > MAG_W) ? SUM_W : MAG_W;

    // ---- configuration registers ----
    logic [MAG_W-1:0]  r_low_mag_sq;
    logic [MAG_W-1:0]  r_high_mag_sq;
    logic [TILT_W-1:0] r_tilt_factor;
    logic [TICK_W-1:0] r_confirm_ticks;
    logic [TICK_W-1:0] r_blink_period;
    logic [TICK_W-1:0] r_blink_on_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_mag_sq     <= LOW_MAG_SQ_RST;
            r_high_mag_sq    <= HIGH_MAG_SQ_RST;
            r_tilt_factor    <= TILT_FACTOR_RST;
            r_confirm_ticks  <= CONFIRM_TICKS_RST;
            r_blink_period   <= BLINK_PERIOD_RST;
            r_blink_on_ticks <= BLINK_ON_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOW_MAG_SQ:     r_low_mag_sq     <= i_cfg_data[MAG_W-1:0];
                CFG_HIGH_MAG_SQ:    r_high_mag_sq    <= i_cfg_data[MAG_W-1:0];
                CFG_TILT_FACTOR_Q8: r_tilt_factor    <= i_cfg_data[TILT_W-1:0];
                CFG_CONFIRM_TICKS:  r_confirm_ticks  <= i_cfg_data[TICK_W-1:0];
                CFG_BLINK_PERIOD:   r_blink_period   <= i_cfg_data[TICK_W-1:0];
                CFG_BLINK_ON_TICKS: r_blink_on_ticks <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- request fields and magnitudes ----
    logic [SB-1:0] in_x, in_y, in_z;
    logic [SB-1:0] abs_x, abs_y, abs_z;
    logic          in_key;
    logic          req_accept;

    assign in_x       = s_axis_tdata[SB-1:0];
    assign in_y       = s_axis_tdata[FIELD_W+SB-1:FIELD_W];
    assign in_z       = s_axis_tdata[2*FIELD_W+SB-1:2*FIELD_W];
    assign in_key     = s_axis_tdata[3*FIELD_W];
    assign req_accept = s_axis_tvalid && s_axis_tready;

    // most negative value maps to 2^(SB-1), which still fits unsigned
    assign abs_x = in_x[SB-1] ? (~in_x + 1'b1) : in_x;
    assign abs_y = in_y[SB-1] ? (~in_y + 1'b1) : in_y;
    assign abs_z = in_z[SB-1] ? (~in_z + 1'b1) : in_z;

    // ---- sequencer ----
    t_seq_state r_state, n_state;
    logic       out_free;
    logic       mod_done;
    logic       r_out_valid;

    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // controller state, initialised on reset (mode, display and ticks to zero, LED, buzzer and heartbeat high)
    t_mode           r_mode, n_mode;
    t_disp           r_disp, n_disp;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic            r_hb, n_hb;
    logic            r_led, n_led;
    logic            r_buz, n_buz;
    logic            n_pulse;

    always_comb begin
        n_state = r_state;
        case (r_state)
            SEQ_IDLE: begin
                if (req_accept) begin
                    if (in_key) begin
                        n_state = SEQ_DONE;
                    end else begin
                        case (r_mode)
                            MODE_NORMAL: n_state = SEQ_SQX;
                            MODE_ALARM:  n_state = SEQ_MOD;
                            default:     n_state = SEQ_DONE;
                        endcase
                    end
                end
            end
            SEQ_SQX:  n_state = SEQ_SQY;
            SEQ_SQY:  n_state = SEQ_SQZ;
            SEQ_SQZ:  n_state = SEQ_TLX;
            SEQ_TLX:  n_state = SEQ_TLY;
            SEQ_TLY:  n_state = SEQ_EVAL;
            SEQ_EVAL: n_state = SEQ_DONE;
            SEQ_MOD: begin
                if (mod_done) begin
                    n_state = SEQ_DONE;
                end
            end
            SEQ_DONE: begin
                if (out_free) begin
                    n_state = SEQ_IDLE;
                end
            end
            default:  n_state = SEQ_IDLE;
        endcase
    end

    // ---- sequencer outputs: multiplier operands and strobes ----
    logic [SB-1:0]  r_ax, r_ay, r_az;
    logic [SQ_W-1:0] r_x2, r_y2, r_z2;
    logic [PW-1:0]  mul_p;
    logic [A_W-1:0] mul_a;
    logic [B_W-1:0] mul_b;
    logic           mod_start;
    logic           load_out;

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        mod_start = 1'b0;
        load_out  = 1'b0;
        s_axis_tready = 1'b0;
        case (r_state)
            SEQ_IDLE: begin
                s_axis_tready = 1'b1;
                mod_start     = req_accept && !in_key && (r_mode == MODE_ALARM);
            end
            SEQ_SQX: begin
                mul_a = A_W'(r_ax);
                mul_b = B_W'(r_ax);
            end
            SEQ_SQY: begin
                mul_a = A_W'(r_ay);
                mul_b = B_W'(r_ay);
            end
            SEQ_SQZ: begin
                mul_a = A_W'(r_az);
                mul_b = B_W'(r_az);
            end
            SEQ_TLX: begin
                // z squared is still on the product register here
                mul_a = A_W'(r_y2) + A_W'(mul_p[SQ_W-1:0]);
                mul_b = B_W'(r_tilt_factor);
            end
            SEQ_TLY: begin
                mul_a = A_W'(r_x2) + A_W'(r_z2);
                mul_b = B_W'(r_tilt_factor);
            end
            SEQ_DONE: load_out = out_free;
            default: ;
        endcase
    end

    fdac_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    logic [TICK_W:0]   mod_divisor;
    logic [TICK_W-1:0] mod_rem;

    // zero period stands for a divisor of 2^16
    assign mod_divisor = (r_blink_period == '0) ? {1'b1, {TICK_W{1'b0}}}
                                                : {1'b0, r_blink_period};

    fdac_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_ticks),
        .i_divisor  (mod_divisor),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // ---- datapath registers ----
    logic             r_key;
    logic             r_tilt_x;
    logic             r_fall;
    logic             r_level;
    logic [SUM_W-1:0] r_total;
    logic             out_band;
    logic             tilt_y;

    assign out_band = (CMP_W'(r_total) < CMP_W'(r_low_mag_sq))
                   || (CMP_W'(r_total) > CMP_W'(r_high_mag_sq));
    assign tilt_y   = PW'({r_y2, 8'h00}) >= mul_p;

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_key <= in_key;
            r_ax  <= abs_x;
            r_ay  <= abs_y;
            r_az  <= abs_z;
        end
        case (r_state)
            SEQ_SQY: r_x2 <= mul_p[SQ_W-1:0];
            SEQ_SQZ: r_y2 <= mul_p[SQ_W-1:0];
            SEQ_TLX: r_z2 <= mul_p[SQ_W-1:0];
            SEQ_TLY: begin
                r_tilt_x <= PW'({r_x2, 8'h00}) >= mul_p;
                r_total  <= SUM_W'(r_x2) + SUM_W'(r_y2) + SUM_W'(r_z2);
            end
            SEQ_EVAL: r_fall <= out_band && (r_tilt_x || tilt_y);
            SEQ_MOD: begin
                if (mod_done) begin
                    r_level <= !(mod_rem < r_blink_on_ticks);
                end
            end
            default: ;
        endcase
    end

    // ---- controller update for one tick ----
    logic [TICK_W-1:0] ticks_inc;

    assign ticks_inc = r_ticks + 1'b1;

    always_comb begin
        n_mode  = r_mode;
        n_disp  = r_disp;
        n_ticks = r_ticks;
        n_hb    = r_hb;
        n_led   = r_led;
        n_buz   = r_buz;
        n_pulse = 1'b0;
        if (r_key) begin
            n_mode  = MODE_NORMAL;
            n_ticks = '0;
            n_led   = 1'b1;
            n_buz   = 1'b1;
            n_disp  = DISP_BLANK;
        end else begin
            case (r_mode)
                MODE_NORMAL: begin
                    n_hb = !r_hb;
                    if (r_fall) begin
                        n_mode  = MODE_FALL;
                        n_ticks = '0;
                        n_disp  = DISP_FALL;
                    end
                end
                MODE_FALL: begin
                    n_led   = 1'b0;
                    n_buz   = 1'b0;
                    n_ticks = ticks_inc;
                    if (ticks_inc >= r_confirm_ticks) begin
                        n_mode  = MODE_ALARM;
                        n_disp  = DISP_HELP;
                        n_pulse = 1'b1;
                    end
                end
                MODE_ALARM: begin
                    n_led   = r_level;
                    n_buz   = r_level;
                    n_ticks = ticks_inc;
                end
                default: ;   // unused code: outputs only
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NORMAL;
            r_disp  <= DISP_BLANK;
            r_ticks <= '0;
            r_hb    <= 1'b1;
            r_led   <= 1'b1;
            r_buz   <= 1'b1;
        end else if (load_out) begin
            r_mode  <= n_mode;
            r_disp  <= n_disp;
            r_ticks <= n_ticks;
            r_hb    <= n_hb;
            r_led   <= n_led;
            r_buz   <= n_buz;
        end
    end

    // ---- result register ----
    logic [OUT_DATA_W-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= {n_mode, n_pulse, n_disp, n_hb, n_buz, n_led};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---- checks ----
    a_pulse_in_alarm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[5]) |-> (r_out_data[7:6] == MODE_ALARM))
        else $error("alarm pulse without alarming mode");

    a_led_buz_agree : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_led == r_buz)
        else $error("LED and buzzer drive disagree");

    a_mod_done_in_mod : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> (r_state == SEQ_MOD))
        else $error("remainder finished outside its wait state");

    a_accept_leaves_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_accept |=> (r_state != SEQ_IDLE))
        else $error("sequencer stayed idle after a request");

endmodule

### rtl/fdac_mul.sv
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on nothing.
module fdac_mul #(
    parameter int unsigned A_W = 33,
    parameter int unsigned B_W = 16
) (
    input  logic               i_clk,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);

    logic [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_p = r_p;

endmodule

### rtl/fdac_mod.sv
`timescale 1ns / 1ps
// Restoring remainder unit, one quotient bit per cycle.
// Depends on fdac_pkg for the tick width.
module fdac_mod
    import fdac_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TICK_W-1:0] i_dividend,
    input  logic [TICK_W:0]   i_divisor,   // zero period already mapped to 2^16
    output logic              o_done,
    output logic [TICK_W-1:0] o_rem
);

    localparam int unsigned CNT_W = $clog2(TICK_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TICK_W:0]   r_rem;
    logic [TICK_W-1:0] r_div;
    logic [TICK_W:0]   trial;
    logic [TICK_W:0]   n_rem;

    always_comb begin
        trial = {r_rem[TICK_W-1:0], r_div[TICK_W-1]};
        n_rem = (trial >= i_divisor) ? trial - i_divisor : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(TICK_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_div <= {r_div[TICK_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[TICK_W-1:0];

endmodule

### dv/tb_fall_detect_alarm_controller_top.sv
`timescale 1ns / 1ps
// Testbench for fall_detect_alarm_controller_top: directed tick table, then randomised
// configuration phases; every result checked against the table or a local alarm predictor.
// Depends on fdac_pkg and the RTL of the top level only.
module tb_fall_detect_alarm_controller_top;
    import fdac_pkg::*;

    localparam int unsigned LIMIT_CYCLES  = 400000;
    localparam int unsigned SETTLE_CYCLES = 32;   // settle time after the last result has been taken
    localparam int unsigned LONG_HOLD     = 300;  // result side hold-off, fills the block
    localparam int unsigned PHASES        = 8;
    localparam int unsigned PHASE_TICKS   = 130;
    localparam int unsigned MAX_PRINTS    = 40;

    // one result, laid out exactly as m_axis_tdata (led in bit 0 up to mode in [7:6])
    typedef struct packed {
        t_mode mode;
        logic  pulse;
        t_disp disp;
        logic  hb;
        logic  buz;
        logic  led;
    } alarm_out_t;

    typedef enum bit {ROW_TICK, ROW_CFG} row_kind_t;

    // one line of the directed table: either a tick request or a register write
    typedef struct {
        row_kind_t         kind;
        t_cfg_idx          idx;
        logic [31:0]       val;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic              key;
        bit                typed;   // expected result written into the table
        alarm_out_t        want;
    } row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [15:0] accel_x_sample, [31:16] accel_y_sample, [47:32] accel_z_sample,
    // [48] key_pressed, [55:49] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [0] alarm_led_n, [1] buzzer_n, [2] heartbeat_led, [4:3] display_mode,
    // [5] alarm_pulse, [7:6] mode_now
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    fall_detect_alarm_controller_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // Predictor: own copy of the registers and controller state
    // ------------------------------------------------------------------
    logic [31:0] cf_low, cf_high;
    logic [9:0]  cf_tilt;
    logic [15:0] cf_confirm, cf_period, cf_on;

    t_mode       st_mode;
    logic [15:0] st_ticks;
    logic        st_hb, st_led, st_buz;
    t_disp       st_disp;

    alarm_out_t  pending_status[$];   // expected results, oldest first
    row_t        stim_plan[$];
    int unsigned err_cnt;
    int unsigned results_seen;
    int unsigned cycle_cnt;
    bit          calm;                // last phase: no idling on either side
    bit          hold_off_req;        // asks the result side for one long hold-off

    function automatic void reset_model();
        cf_low     = LOW_MAG_SQ_RST;
        cf_high    = HIGH_MAG_SQ_RST;
        cf_tilt    = TILT_FACTOR_RST;
        cf_confirm = CONFIRM_TICKS_RST;
        cf_period  = BLINK_PERIOD_RST;
        cf_on      = BLINK_ON_TICKS_RST;
        st_mode    = MODE_NORMAL;
        st_ticks   = '0;
        st_hb      = 1'b1;
        st_led     = 1'b1;
        st_buz     = 1'b1;
        st_disp    = DISP_BLANK;
    endfunction

    // out of the magnitude band and steep on x or y; all products exact in 64 bits
    function automatic logic fall_suspected(logic signed [15:0] x, logic signed [15:0] y,
                                            logic signed [15:0] z);
        longint          sx, sy, sz;
        longint unsigned x2, y2, z2, total;
        logic            out_band, tilt_x, tilt_y;
        sx = x;
        sy = y;
        sz = z;
        if (sx < 0) sx = -sx;
        if (sy < 0) sy = -sy;
        if (sz < 0) sz = -sz;
        x2 = sx * sx;
        y2 = sy * sy;
        z2 = sz * sz;
        total    = x2 + y2 + z2;
        out_band = (total < cf_low) || (total > cf_high);
        tilt_x   = (x2 << 8) >= cf_tilt * (y2 + z2);
        tilt_y   = (y2 << 8) >= cf_tilt * (x2 + z2);
        return out_band && (tilt_x || tilt_y);
    endfunction

    // one tick of the controller; returns the outputs after the update
    function automatic alarm_out_t advance_alarm(logic signed [15:0] x, logic signed [15:0] y,
                                                 logic signed [15:0] z, logic key);
        alarm_out_t  r;
        logic [16:0] period;
        logic [16:0] phase;
        logic        pulse;
        pulse = 1'b0;
        if (key) begin
            // key press wins: back to normal, heartbeat frozen, no fall test
            st_mode  = MODE_NORMAL;
            st_ticks = '0;
            st_led   = 1'b1;
            st_buz   = 1'b1;
            st_disp  = DISP_BLANK;
        end else begin
            case (st_mode)
                MODE_NORMAL: begin
                    st_hb = ~st_hb;
                    if (fall_suspected(x, y, z)) begin
                        st_mode  = MODE_FALL;
                        st_ticks = '0;
                        st_disp  = DISP_FALL;
                    end
                end
                MODE_FALL: begin
                    st_led   = 1'b0;
                    st_buz   = 1'b0;
                    st_ticks = st_ticks + 16'd1;
                    if (st_ticks >= cf_confirm) begin
                        st_mode = MODE_ALARM;
                        st_disp = DISP_HELP;
                        pulse   = 1'b1;
                    end
                end
                MODE_ALARM: begin
                    // zero period stands for 65536, phase is then the tick count itself
                    period   = (cf_period == 16'd0) ? 17'h10000 : {1'b0, cf_period};
                    phase    = st_ticks % period;
                    st_led   = !(phase < cf_on);
                    st_buz   = !(phase < cf_on);
                    st_ticks = st_ticks + 16'd1;
                end
                default: ;
            endcase
        end
        r.led   = st_led;
        r.buz   = st_buz;
        r.hb    = st_hb;
        r.disp  = st_disp;
        r.pulse = pulse;
        r.mode  = st_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Table helpers
    // ------------------------------------------------------------------
    function automatic row_t tick_row(logic signed [15:0] x, logic signed [15:0] y,
                                      logic signed [15:0] z, logic key);
        row_t r;
        r.kind  = ROW_TICK;
        r.idx   = CFG_LOW_MAG_SQ;
        r.val   = '0;
        r.x     = x;
        r.y     = y;
        r.z     = z;
        r.key   = key;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic row_t typed_row(logic signed [15:0] x, logic signed [15:0] y,
                                       logic signed [15:0] z, logic key, alarm_out_t want);
        row_t r;
        r       = tick_row(x, y, z, key);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic row_t cfg_row(t_cfg_idx idx, logic [31:0] val);
        row_t r;
        r      = tick_row('0, '0, '0, 1'b0);
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic alarm_out_t outcome(logic led, logic buz, logic hb, t_disp disp,
                                           logic pulse, t_mode mode);
        alarm_out_t r;
        r.led   = led;
        r.buz   = buz;
        r.hb    = hb;
        r.disp  = disp;
        r.pulse = pulse;
        r.mode  = mode;
        return r;
    endfunction

    // random axis value: 0 full range, 1 small, 2 large, else an extreme
    function automatic logic signed [15:0] pick_axis(int unsigned flavour);
        logic signed [15:0] v;
        case (flavour)
            0: v = $urandom;
            1: v = $urandom_range(0, 3000);
            2: v = $urandom_range(15000, 32767);
            default: begin
                case ($urandom_range(0, 4))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    2:       v = -16'sd1;
                    3:       v = 16'sd0;
                    default: v = 16'sd1;
                endcase
            end
        endcase
        if ((flavour == 1 || flavour == 2) && $urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic note_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic cmp_field(string name, logic [1:0] got, logic [1:0] want);
        if (got !== want) note_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    // register write at the next edge; write enable is lowered by the caller
    // after the batch so it is never dropped and raised in one step
    task automatic set_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_LOW_MAG_SQ:     cf_low     = val;
            CFG_HIGH_MAG_SQ:    cf_high    = val;
            CFG_TILT_FACTOR_Q8: cf_tilt    = val[9:0];
            CFG_CONFIRM_TICKS:  cf_confirm = val[15:0];
            CFG_BLINK_PERIOD:   cf_period  = val[15:0];
            CFG_BLINK_ON_TICKS: cf_on      = val[15:0];
            default: ;
        endcase
    endtask

    // offer one tick request and hold it until taken; valid stays high so a
    // following request can go out back to back
    task automatic send_tick(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic key, bit typed, alarm_out_t want);
        alarm_out_t pred;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, key, z, y, x};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = advance_alarm(x, y, z, key);
        pending_status.push_back(typed ? want : pred);
    endtask

    // stop offering, wait for every outstanding result, then let the block settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic draw_config();
        logic [31:0] low;
        logic [31:0] high;
        low  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(50000000, 900000000);
        high = ($urandom_range(0, 3) == 0) ? $urandom : low + $urandom_range(0, 1500000000);
        set_reg(CFG_LOW_MAG_SQ, low);
        set_reg(CFG_HIGH_MAG_SQ, high);
        set_reg(CFG_TILT_FACTOR_Q8, $urandom_range(0, 1023));
        // short confirm times mostly, so the alarm state is reached often
        set_reg(CFG_CONFIRM_TICKS, ($urandom_range(0, 5) == 0) ? $urandom_range(21, 400)
                                                                : $urandom_range(0, 20));
        set_reg(CFG_BLINK_PERIOD, $urandom_range(0, 12));
        set_reg(CFG_BLINK_ON_TICKS, $urandom_range(0, 14));
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat (calm ? 1 : $urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    // checker: each accepted result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        alarm_out_t got;
        alarm_out_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got = alarm_out_t'(m_axis_tdata);
            if (pending_status.size() == 0) begin
                note_mismatch($sformatf("result 0x%02h with no request pending", m_axis_tdata));
            end else begin
                want = pending_status.pop_front();
                cmp_field("alarm_led_n", got.led, want.led);
                cmp_field("buzzer_n", got.buz, want.buz);
                cmp_field("heartbeat_led", got.hb, want.hb);
                cmp_field("display_mode", got.disp, want.disp);
                cmp_field("alarm_pulse", got.pulse, want.pulse);
                cmp_field("mode_now", got.mode, want.mode);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        bit          in_cfg;
        int unsigned style;
        int unsigned fx, fy, fz;
        row_t        r;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_LOW_MAG_SQ;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        err_cnt      = 0;
        results_seen = 0;
        cycle_cnt    = 0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        in_cfg       = 1'b0;
        reset_model();

        // reset defaults: quiet in-band sample, then heartbeat toggles
        stim_plan.push_back(typed_row(16'sd0, 16'sd0, 16'sd25000, 1'b0,
                                      outcome(1'b1, 1'b1, 1'b0, DISP_BLANK, 1'b0, MODE_NORMAL)));
        stim_plan.push_back(tick_row(16'sh8000, 16'sd0, 16'sd0, 1'b0));      // in band, top edge
        stim_plan.push_back(tick_row(16'sh7fff, 16'sh8000, 16'sd0, 1'b0));   // out of band, upright
        // all zero: free fall, tilt holds trivially
        stim_plan.push_back(typed_row(16'sd0, 16'sd0, 16'sd0, 1'b0,
                                      outcome(1'b1, 1'b1, 1'b1, DISP_FALL, 1'b0, MODE_FALL)));
        stim_plan.push_back(typed_row(16'sd1, 16'sd2, 16'sd3, 1'b0,
                                      outcome(1'b0, 1'b0, 1'b1, DISP_FALL, 1'b0, MODE_FALL)));
        // key press clears at once, heartbeat held
        stim_plan.push_back(typed_row(-16'sd1, -16'sd1, -16'sd1, 1'b1,
                                      outcome(1'b1, 1'b1, 1'b1, DISP_BLANK, 1'b0, MODE_NORMAL)));
        // zero confirm alarms after one tick; zero period means a 65536 tick blink period
        stim_plan.push_back(cfg_row(CFG_CONFIRM_TICKS, 32'd0));
        stim_plan.push_back(cfg_row(CFG_BLINK_PERIOD, 32'd0));
        stim_plan.push_back(cfg_row(CFG_BLINK_ON_TICKS, 32'd1));
        stim_plan.push_back(cfg_row(CFG_TILT_FACTOR_Q8, 32'd1023));
        stim_plan.push_back(tick_row(16'sd3, -16'sd20000, 16'sd7, 1'b0));    // steep on y only
        stim_plan.push_back(typed_row(16'sd5, 16'sd5, 16'sd5, 1'b0,
                                      outcome(1'b0, 1'b0, 1'b0, DISP_HELP, 1'b1, MODE_ALARM)));
        stim_plan.push_back(tick_row(16'sd0, 16'sd0, 16'sd0, 1'b0));
        stim_plan.push_back(tick_row(16'sd0, 16'sd0, 16'sd0, 1'b0));
        stim_plan.push_back(tick_row(16'sd9, 16'sd9, 16'sd9, 1'b1));
        // register extremes: everything under the band, tilt test always true
        stim_plan.push_back(cfg_row(CFG_LOW_MAG_SQ, 32'hffff_ffff));
        stim_plan.push_back(cfg_row(CFG_HIGH_MAG_SQ, 32'hffff_ffff));
        stim_plan.push_back(cfg_row(CFG_TILT_FACTOR_Q8, 32'd0));
        stim_plan.push_back(cfg_row(CFG_CONFIRM_TICKS, 32'd65535));
        stim_plan.push_back(cfg_row(CFG_BLINK_PERIOD, 32'd65535));
        stim_plan.push_back(cfg_row(CFG_BLINK_ON_TICKS, 32'd65535));
        stim_plan.push_back(tick_row(16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
        stim_plan.push_back(tick_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0));
        stim_plan.push_back(tick_row(16'sd0, 16'sd0, 16'sd0, 1'b1));
        // empty band: zero total sits on both edges, anything else is outside
        stim_plan.push_back(cfg_row(CFG_LOW_MAG_SQ, 32'd0));
        stim_plan.push_back(cfg_row(CFG_HIGH_MAG_SQ, 32'd0));
        stim_plan.push_back(cfg_row(CFG_TILT_FACTOR_Q8, 32'd256));
        stim_plan.push_back(cfg_row(CFG_CONFIRM_TICKS, 32'd2));
        stim_plan.push_back(cfg_row(CFG_BLINK_PERIOD, 32'd3));
        stim_plan.push_back(cfg_row(CFG_BLINK_ON_TICKS, 32'd2));
        stim_plan.push_back(tick_row(16'sd0, 16'sd0, 16'sd0, 1'b0));
        stim_plan.push_back(tick_row(16'sd1, 16'sd1, 16'sd1, 1'b0));         // tilt just short
        stim_plan.push_back(tick_row(16'sd1, 16'sd0, 16'sd0, 1'b0));         // fall
        stim_plan.push_back(tick_row(16'sd0, 16'sd0, 16'sd0, 1'b0));
        stim_plan.push_back(tick_row(16'sd0, 16'sd0, 16'sd0, 1'b0));         // to alarming
        stim_plan.push_back(tick_row(16'sd0, 16'sd0, 16'sd0, 1'b0));         // blink off
        stim_plan.push_back(tick_row(16'sd0, 16'sd0, 16'sd0, 1'b0));         // blink on
        stim_plan.push_back(tick_row(16'sd0, 16'sd0, 16'sd0, 1'b0));
        stim_plan.push_back(tick_row(16'sd0, 16'sd0, 16'sd0, 1'b1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; register writes only once the block has drained
        foreach (stim_plan[i]) begin
            r = stim_plan[i];
            if (r.kind == ROW_CFG) begin
                if (!in_cfg) begin
                    drain_results();
                    in_cfg = 1'b1;
                end
                set_reg(r.idx, r.val);
            end else begin
                if (in_cfg) begin
                    i_cfg_we <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_tick(r.x, r.y, r.z, r.key, r.typed, r.want);
            end
        end

        // random phases, each under a fresh register setting
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            drain_results();
            calm = (ph == PHASES - 1);
            draw_config();
            // one long result-side hold-off while requests keep coming
            if (ph == 1) hold_off_req = 1'b1;
            for (int unsigned k = 0; k < PHASE_TICKS; k++) begin
                // sender pause until the block has handed back everything
                if (ph == 3 && k == PHASE_TICKS / 2) drain_results();
                if (!calm && $urandom_range(0, 6) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(posedge i_clk);
                end
                style = $urandom_range(0, 9);
                if (style < 3) begin
                    fx = 0; fy = 0; fz = 0;
                end else if (style < 6) begin
                    fx = 1; fy = 1; fz = 1;
                end else if (style < 8) begin
                    // one dominant axis: the steep tilt cases
                    fx = 1; fy = 1; fz = 1;
                    if ($urandom_range(0, 1) == 1) fx = 2;
                    else fy = 2;
                end else begin
                    fx = 3; fy = 3; fz = 3;
                end
                send_tick(pick_axis(fx), pick_axis(fy), pick_axis(fz),
                          ($urandom_range(0, 19) == 0), 1'b0, '0);
            end
        end

        drain_results();
        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sim.f
rtl/fdac_pkg.sv
rtl/fdac_mul.sv
rtl/fdac_mod.sv
rtl/fall_detect_alarm_controller_top.sv
dv/tb_fall_detect_alarm_controller_top.sv
